@@ src/ppk_pkg.sv @@
// ----------------------------------------------------------------------------
// ppk_pkg
// Shared types and constants of the pixel point operation and colour key unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ppk_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [7:0] PIX_MAX    = 8'd255;
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    localparam logic [3:0] MODE_GRAY_BELOW = 4'd0;
    localparam logic [3:0] MODE_GRAY_BAND  = 4'd1;
    localparam logic [3:0] MODE_GRAY_INV   = 4'd2;
    localparam logic [3:0] MODE_GRAY_ADD   = 4'd3;
    localparam logic [3:0] MODE_RGB_INV    = 4'd4;
    localparam logic [3:0] MODE_RGB_ADD    = 4'd5;
    localparam logic [3:0] MODE_TO_GRAY    = 4'd6;
    localparam logic [3:0] MODE_RGB_BELOW  = 4'd7;
    localparam logic [3:0] MODE_RGB_BAND   = 4'd8;
    localparam logic [3:0] MODE_L1_KEY     = 4'd9;
    localparam logic [3:0] MODE_L2_KEY     = 4'd10;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_GRAY_LOW  = 3'd1;
    localparam logic [2:0] REG_GRAY_HIGH = 3'd2;
    localparam logic [2:0] REG_RGB_LOW   = 3'd3;
    localparam logic [2:0] REG_RGB_HIGH  = 3'd4;
    localparam logic [2:0] REG_ADD_RGB   = 3'd5;
    localparam logic [2:0] REG_REF_RGB   = 3'd6;
    localparam logic [2:0] REG_DIST_THR  = 3'd7;

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  gray_low;
        logic [8:0]  gray_high;
        logic [23:0] rgb_low;
        logic [26:0] rgb_high;
        logic [23:0] add_rgb;
        logic [23:0] ref_rgb;
        logic [9:0]  dist_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:           4'd0,
        gray_low:       8'd0,
        gray_high:      9'd128,
        rgb_low:        24'd0,
        rgb_high:       27'd0,
        add_rgb:        24'd0,
        ref_rgb:        24'd0,
        dist_threshold: 10'd0
    };

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] gray_in;
        logic       last_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] gray_out;
        logic       last_out;
    } pix_out_t;

endpackage

`default_nettype wire

@@ src/ppk_regs.sv @@
// ----------------------------------------------------------------------------
// ppk_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_regs
    import ppk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_MODE:      cfg_next.mode           = pwdata[3:0];
                REG_GRAY_LOW:  cfg_next.gray_low       = pwdata[7:0];
                REG_GRAY_HIGH: cfg_next.gray_high      = pwdata[8:0];
                REG_RGB_LOW:   cfg_next.rgb_low        = pwdata[23:0];
                REG_RGB_HIGH:  cfg_next.rgb_high       = pwdata[26:0];
                REG_ADD_RGB:   cfg_next.add_rgb        = pwdata[23:0];
                REG_REF_RGB:   cfg_next.ref_rgb        = pwdata[23:0];
                REG_DIST_THR:  cfg_next.dist_threshold = pwdata[9:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_MODE:      prdata = DATA_W'(cfg_reg.mode);
            REG_GRAY_LOW:  prdata = DATA_W'(cfg_reg.gray_low);
            REG_GRAY_HIGH: prdata = DATA_W'(cfg_reg.gray_high);
            REG_RGB_LOW:   prdata = DATA_W'(cfg_reg.rgb_low);
            REG_RGB_HIGH:  prdata = DATA_W'(cfg_reg.rgb_high);
            REG_ADD_RGB:   prdata = DATA_W'(cfg_reg.add_rgb);
            REG_REF_RGB:   prdata = DATA_W'(cfg_reg.ref_rgb);
            REG_DIST_THR:  prdata = DATA_W'(cfg_reg.dist_threshold);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ src/ppk_pipe.sv @@
// ----------------------------------------------------------------------------
// ppk_pipe
// Three-stage pixel datapath: channel ops, products, key decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_pipe
    import ppk_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    pix_valid,
    output logic         pix_stall,
    input  wire pix_in_t pix,
    output logic         res_valid,
    input  wire logic    res_stall,
    output pix_out_t     res
);

    typedef struct packed {
        pix_out_t   px;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
        logic [9:0] sum;
    } s1_t;

    typedef struct packed {
        pix_out_t    px;
        logic [15:0] sq0;
        logic [15:0] sq1;
        logic [15:0] sq2;
        logic [9:0]  l1;
        logic [19:0] thr_sq;
    } s2_t;

    logic     v1_reg, v2_reg, v3_reg;
    logic     v1_next, v2_next, v3_next;
    logic     adv1, adv2, adv3;
    s1_t      s1_reg, s1_next;
    s2_t      s2_reg, s2_next;
    pix_out_t s3_reg, s3_next;

    logic [7:0] ch  [3];
    logic [7:0] lo  [3];
    logic [8:0] hi  [3];
    logic [7:0] ad  [3];
    logic [7:0] rf  [3];
    logic [7:0] oc  [3];
    logic [7:0] ed  [3];
    logic [8:0] sa  [3];
    logic       inb [3];
    logic [8:0] gsum;
    logic [19:0] prod3;
    logic [17:0] d2;
    logic        key;

    assign adv3      = !v3_reg || !res_stall;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign pix_stall = !adv1;
    assign res_valid = v3_reg;
    assign res       = s3_reg;

    assign v1_next = adv1 ? pix_valid : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;
    assign v3_next = adv3 ? v2_reg : v3_reg;

    // stage 1: per-channel operations
    always_comb
    begin
        ch[0] = pix.red_in;
        ch[1] = pix.green_in;
        ch[2] = pix.blue_in;
        for (int i = 0; i < 3; i++)
        begin
            lo[i]  = cfg.rgb_low[16-8*i +: 8];
            hi[i]  = cfg.rgb_high[18-9*i +: 9];
            ad[i]  = cfg.add_rgb[16-8*i +: 8];
            rf[i]  = cfg.ref_rgb[16-8*i +: 8];
            sa[i]  = {1'b0, ch[i]} + {1'b0, ad[i]};
            ed[i]  = (ch[i] > rf[i]) ? (ch[i] - rf[i]) : (rf[i] - ch[i]);
            inb[i] = (ch[i] > lo[i]) && ({1'b0, ch[i]} < hi[i]);
            oc[i]  = ch[i];
        end
        gsum = {1'b0, pix.gray_in} + {1'b0, cfg.add_rgb[23:16]};

        s1_next.px.gray_out = pix.gray_in;
        s1_next.px.last_out = pix.last_pixel;
        case (cfg.mode)
            MODE_GRAY_BELOW:
                s1_next.px.gray_out = ({1'b0, pix.gray_in} < cfg.gray_high) ? PIX_MAX : '0;
            MODE_GRAY_BAND:
                s1_next.px.gray_out = ((pix.gray_in > cfg.gray_low)
                    && ({1'b0, pix.gray_in} < cfg.gray_high)) ? PIX_MAX : '0;
            MODE_GRAY_INV:
                s1_next.px.gray_out = PIX_MAX - pix.gray_in;
            MODE_GRAY_ADD:
                s1_next.px.gray_out = gsum[8] ? PIX_MAX : gsum[7:0];
            MODE_RGB_INV:
                for (int i = 0; i < 3; i++) oc[i] = PIX_MAX - ch[i];
            MODE_RGB_ADD:
                for (int i = 0; i < 3; i++) oc[i] = sa[i][8] ? PIX_MAX : sa[i][7:0];
            MODE_RGB_BELOW:
                for (int i = 0; i < 3; i++) oc[i] = ({1'b0, ch[i]} < hi[i]) ? PIX_MAX : '0;
            MODE_RGB_BAND:
                for (int i = 0; i < 3; i++) oc[i] = (inb[0] && inb[1] && inb[2]) ? PIX_MAX : '0;
            default:
                s1_next.px.gray_out = pix.gray_in;
        endcase
        s1_next.px.red_out   = oc[0];
        s1_next.px.green_out = oc[1];
        s1_next.px.blue_out  = oc[2];
        s1_next.e0  = ed[0];
        s1_next.e1  = ed[1];
        s1_next.e2  = ed[2];
        s1_next.sum = {2'b00, ch[0]} + {2'b00, ch[1]} + {2'b00, ch[2]};
    end

    // stage 2: squares, L1 sum, divide by three
    always_comb
    begin
        prod3          = s1_reg.sum * DIV3_MUL;
        s2_next.px     = s1_reg.px;
        if (cfg.mode == MODE_TO_GRAY)
        begin
            s2_next.px.gray_out = prod3[DIV3_SHIFT +: 8];
        end
        s2_next.sq0    = s1_reg.e0 * s1_reg.e0;
        s2_next.sq1    = s1_reg.e1 * s1_reg.e1;
        s2_next.sq2    = s1_reg.e2 * s1_reg.e2;
        s2_next.l1     = {2'b00, s1_reg.e0} + {2'b00, s1_reg.e1} + {2'b00, s1_reg.e2};
        s2_next.thr_sq = cfg.dist_threshold * cfg.dist_threshold;
    end

    // stage 3: key decision
    always_comb
    begin
        d2      = {2'b00, s2_reg.sq0} + {2'b00, s2_reg.sq1} + {2'b00, s2_reg.sq2};
        s3_next = s2_reg.px;
        key     = 1'b0;
        case (cfg.mode)
            MODE_L1_KEY: key = s2_reg.l1 < cfg.dist_threshold;
            MODE_L2_KEY: key = {2'b00, d2} < s2_reg.thr_sq;
            default:     key = 1'b0;
        endcase
        if (cfg.mode == MODE_L1_KEY || cfg.mode == MODE_L2_KEY)
        begin
            s3_next.red_out   = key ? '0 : PIX_MAX;
            s3_next.green_out = key ? '0 : PIX_MAX;
            s3_next.blue_out  = key ? '0 : PIX_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
        if (adv3)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

`default_nettype wire

@@ src/pixel_point_op_and_color_key_unit.sv @@
// ----------------------------------------------------------------------------
// pixel_point_op_and_color_key_unit
// Point operations and colour keying on a stream of pixel words.
//
// Pixel words enter on pix (pix_valid / pix_stall) and result words leave
// on res (res_valid / res_stall); a word moves at a clock edge where valid
// is high and stall is low. One result word leaves for every pixel word.
// The datapath has three register stages (s1_reg, s2_reg, s3_reg). A new
// pixel word is taken every cycle while pix_stall is low; throughput is one
// word per clock when the output is not stalled.
// When res_stall is held, the stages fill up and pix_stall rises only once
// all three hold a word; no word is dropped or repeated.
// The user must write the mode and threshold registers over the APB-style
// port only with no pixels in flight, not enforced; pready is always high.
// Reset empties the pipeline and loads the register reset values
// (gray_high 128, all others 0).
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_point_op_and_color_key_unit
    import ppk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              pix_valid,
    output logic                   pix_stall,
    input  wire pix_in_t           pix,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output pix_out_t               res
);

    cfg_t cfg;

    ppk_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppk_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

@@ src/ppk_checker.sv @@
// ----------------------------------------------------------------------------
// ppk_checker
// Port-level checks of the pixel point operation and colour key unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_checker
    import ppk_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [DATA_W-1:0] pwdata,
    input wire logic [DATA_W-1:0] prdata,
    input wire logic              pix_stall,
    input wire logic              res_valid,
    input wire logic              res_stall,
    input wire pix_out_t          res
);

    // hold a stalled result word
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result word changed");

    // back-pressure only with a full, stalled output
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid && res_stall)
        else $error("pixel input stalled without output back-pressure");

    // empty after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid straight after reset");

    // mode readback follows the last write
    a_mode_rb: assert property (@(posedge clk) disable iff (!rst_n)
        $past(psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_MODE)
        && paddr[ADDR_W-1:2] == REG_MODE |-> prdata[3:0] == $past(pwdata[3:0]))
        else $error("mode readback mismatch");

endmodule

bind pixel_point_op_and_color_key_unit ppk_checker u_ppk_checker (.*);

`default_nettype wire

@@ dv/ppk_result_checker.sv @@
// ----------------------------------------------------------------------------
// ppk_result_checker
// Watches the register port and both pixel channels of the point operation
// and colour key unit. It keeps its own copy of the registers, works out the
// result word for every pixel word taken, and compares each result word that
// leaves the block, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ppk_result_checker
    import ppk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    input  logic              pix_valid,
    input  logic              pix_stall,
    input  pix_in_t           pix,
    input  logic              res_valid,
    input  logic              res_stall,
    input  pix_out_t          res,
    output int                fail_count,
    output int                pending
);

    localparam int GRAY_DIVISOR = 3;

    cfg_t     shadow_regs;
    pix_out_t due_results[$];

    function automatic logic [7:0] clamp_sum(logic [7:0] a, logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? PIX_MAX : s[7:0];
    endfunction

    function automatic pix_out_t apply_point_op(pix_in_t p, cfg_t c);
        pix_out_t   o;
        logic [7:0] ch [3];
        logic [7:0] lo [3];
        logic [7:0] add [3];
        logic [7:0] refc [3];
        logic [8:0] hi [3];
        logic [7:0] gy;
        logic [9:0] sum;
        int         dsum;
        int         e;
        bit         in_range;
        ch[0] = p.red_in;
        ch[1] = p.green_in;
        ch[2] = p.blue_in;
        gy = p.gray_in;
        lo[0] = c.rgb_low[23:16];
        lo[1] = c.rgb_low[15:8];
        lo[2] = c.rgb_low[7:0];
        add[0] = c.add_rgb[23:16];
        add[1] = c.add_rgb[15:8];
        add[2] = c.add_rgb[7:0];
        refc[0] = c.ref_rgb[23:16];
        refc[1] = c.ref_rgb[15:8];
        refc[2] = c.ref_rgb[7:0];
        hi[0] = c.rgb_high[26:18];
        hi[1] = c.rgb_high[17:9];
        hi[2] = c.rgb_high[8:0];
        dsum = 0;
        in_range = 1'b1;
        case (c.mode)
            MODE_GRAY_BELOW: gy = ({1'b0, gy} < c.gray_high) ? PIX_MAX : 8'd0;
            MODE_GRAY_BAND:
                gy = (gy > c.gray_low && {1'b0, gy} < c.gray_high) ? PIX_MAX : 8'd0;
            MODE_GRAY_INV: gy = PIX_MAX - gy;
            MODE_GRAY_ADD: gy = clamp_sum(gy, add[0]);
            MODE_RGB_INV:
                for (int i = 0; i < 3; i++) ch[i] = PIX_MAX - ch[i];
            MODE_RGB_ADD:
                for (int i = 0; i < 3; i++) ch[i] = clamp_sum(ch[i], add[i]);
            MODE_TO_GRAY:
            begin
                sum = 10'(ch[0]) + 10'(ch[1]) + 10'(ch[2]);
                gy = 8'(int'(sum) / GRAY_DIVISOR);
            end
            MODE_RGB_BELOW:
                for (int i = 0; i < 3; i++) ch[i] = ({1'b0, ch[i]} < hi[i]) ? PIX_MAX : 8'd0;
            MODE_RGB_BAND:
            begin
                for (int i = 0; i < 3; i++)
                    if (!(ch[i] > lo[i] && {1'b0, ch[i]} < hi[i]))
                        in_range = 1'b0;
                for (int i = 0; i < 3; i++) ch[i] = in_range ? PIX_MAX : 8'd0;
            end
            MODE_L1_KEY:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e = int'(ch[i]) - int'(refc[i]);
                    dsum += (e < 0) ? -e : e;
                end
                in_range = dsum < int'(c.dist_threshold);
                for (int i = 0; i < 3; i++) ch[i] = in_range ? 8'd0 : PIX_MAX;
            end
            MODE_L2_KEY:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e = int'(ch[i]) - int'(refc[i]);
                    dsum += e * e;
                end
                in_range = dsum < int'(c.dist_threshold) * int'(c.dist_threshold);
                for (int i = 0; i < 3; i++) ch[i] = in_range ? 8'd0 : PIX_MAX;
            end
            default: ;
        endcase
        o.red_out   = ch[0];
        o.green_out = ch[1];
        o.blue_out  = ch[2];
        o.gray_out  = gy;
        o.last_out  = p.last_pixel;
        return o;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        if (!rst_n)
        begin
            shadow_regs = '0;
            shadow_regs.gray_high = 9'd128;
            due_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_MODE:      shadow_regs.mode = pwdata[3:0];
                    REG_GRAY_LOW:  shadow_regs.gray_low = pwdata[7:0];
                    REG_GRAY_HIGH: shadow_regs.gray_high = pwdata[8:0];
                    REG_RGB_LOW:   shadow_regs.rgb_low = pwdata[23:0];
                    REG_RGB_HIGH:  shadow_regs.rgb_high = pwdata[26:0];
                    REG_ADD_RGB:   shadow_regs.add_rgb = pwdata[23:0];
                    REG_REF_RGB:   shadow_regs.ref_rgb = pwdata[23:0];
                    REG_DIST_THR:  shadow_regs.dist_threshold = pwdata[9:0];
                    default: ;
                endcase
            end
            if (pix_valid && !pix_stall)
                due_results.push_back(apply_point_op(pix, shadow_regs));
            if (res_valid && !res_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result word expected none, got %h", $time, res);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("red_out", want.red_out, res.red_out);
                    check_field("green_out", want.green_out, res.green_out);
                    check_field("blue_out", want.blue_out, res.blue_out);
                    check_field("gray_out", want.gray_out, res.gray_out);
                    check_field("last_out", want.last_out, res.last_out);
                end
            end
        end
        pending = due_results.size();
    end

endmodule

@@ dv/pixel_point_op_and_color_key_unit_tb.sv @@
// ----------------------------------------------------------------------------
// pixel_point_op_and_color_key_unit_tb
// Drives the point operation and colour key unit: a directed set of pixels
// for every mode and its edge cases, then phases of random pixels under
// random register settings, with random idling on both channels, one long
// receiver hold-off and one stretch without idling. The checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module pixel_point_op_and_color_key_unit_tb;
    import ppk_pkg::*;

    localparam int         N_PHASES        = 13;
    localparam int         WORDS_PER_PHASE = 46;
    localparam int         IDLE_PCT        = 34;
    localparam int         HOLD_CYCLES     = 60;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         SQUEEZE_PHASE   = 2;
    localparam int         STEADY_PHASE    = 5;
    localparam logic [3:0] MODE_SPARE      = 4'd15;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              pix_valid = 1'b0;
    logic              pix_stall;
    pix_in_t           pix = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    pix_out_t          res;

    int fail_count;
    int pending;
    int cycles = 0;
    int hold_left = 0;
    bit steady = 1'b0;
    bit squeeze_req = 1'b0;
    bit squeeze_done = 1'b0;

    pixel_point_op_and_color_key_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    ppk_result_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("pixel_point_op_and_color_key_unit_tb: FAIL");
            $finish;
        end
    end

    // hold off once for a long stretch, otherwise stall at random
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall = 1'b1;
            hold_left--;
        end
        else if (squeeze_req && !squeeze_done)
        begin
            squeeze_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            res_stall = 1'b1;
        end
        else
            res_stall = !steady && ($urandom_range(99) < IDLE_PCT);
    end

    function automatic pix_in_t px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [7:0] y, logic l);
        pix_in_t p;
        p.red_in = r;
        p.green_in = g;
        p.blue_in = b;
        p.gray_in = y;
        p.last_pixel = l;
        return p;
    endfunction

    function automatic logic [7:0] jitter(logic [7:0] base);
        return base + 8'($urandom_range(6)) - 8'd3;
    endfunction

    function automatic pix_in_t rand_pixel(cfg_t c);
        pix_in_t p;
        p = pix_in_t'({$urandom, 1'b0});
        case ($urandom_range(3))
            2:
            begin
                p.red_in = jitter(c.ref_rgb[23:16]);
                p.green_in = jitter(c.ref_rgb[15:8]);
                p.blue_in = jitter(c.ref_rgb[7:0]);
                p.gray_in = jitter(c.gray_low);
            end
            3:
            begin
                p.red_in = jitter($urandom_range(1) ? c.rgb_low[23:16] : c.rgb_high[25:18]);
                p.green_in = jitter($urandom_range(1) ? c.rgb_low[15:8] : c.rgb_high[16:9]);
                p.blue_in = jitter($urandom_range(1) ? c.rgb_low[7:0] : c.rgb_high[7:0]);
                p.gray_in = jitter(c.gray_high[7:0]);
            end
            default: ;
        endcase
        p.last_pixel = ($urandom_range(15) == 0);
        return p;
    endfunction

    function automatic cfg_t make_settings(int ph);
        cfg_t c;
        case (ph % 4)
            0: c = '0;
            1: c = '1;
            default:
            begin
                c.gray_low = 8'($urandom);
                c.gray_high = $urandom_range(3) == 0 ? 9'($urandom) : 9'($urandom_range(256));
                c.rgb_low = 24'($urandom);
                if ($urandom_range(3) == 0)
                    c.rgb_high = 27'($urandom);
                else
                    c.rgb_high = {9'($urandom_range(256)), 9'($urandom_range(256)),
                                  9'($urandom_range(256))};
                c.add_rgb = 24'($urandom);
                c.ref_rgb = 24'($urandom);
                c.dist_threshold = $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(60));
            end
        endcase
        c.mode = (ph < 11) ? 4'(ph) : 4'($urandom_range(15));
        return c;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
    endtask

    task automatic load_settings(cfg_t c);
        write_reg(REG_MODE, DATA_W'(c.mode));
        write_reg(REG_GRAY_LOW, DATA_W'(c.gray_low));
        write_reg(REG_GRAY_HIGH, DATA_W'(c.gray_high));
        write_reg(REG_RGB_LOW, DATA_W'(c.rgb_low));
        write_reg(REG_RGB_HIGH, DATA_W'(c.rgb_high));
        write_reg(REG_ADD_RGB, DATA_W'(c.add_rgb));
        write_reg(REG_REF_RGB, DATA_W'(c.ref_rgb));
        write_reg(REG_DIST_THR, DATA_W'(c.dist_threshold));
    endtask

    // hold the word until it is taken, then advance to the next falling edge
    task automatic send_pixel(pix_in_t p);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            pix_valid = 1'b0;
            @(negedge clk);
        end
        pix = p;
        pix_valid = 1'b1;
        do
            @(posedge clk);
        while (pix_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        pix_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        cfg_t d;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pixel(px(8'd0, 8'd0, 8'd0, 8'd127, 1'b0));
        send_pixel(px(8'd255, 8'd255, 8'd255, 8'd128, 1'b1));
        send_pixel(px(8'd1, 8'd2, 8'd3, 8'd0, 1'b0));

        d = '0;
        d.mode = MODE_GRAY_BAND;
        d.gray_low = 8'd10;
        d.gray_high = 9'd256;
        drain();
        load_settings(d);
        send_pixel(px(8'd5, 8'd6, 8'd7, 8'd10, 1'b0));
        send_pixel(px(8'd5, 8'd6, 8'd7, 8'd11, 1'b0));
        send_pixel(px(8'd5, 8'd6, 8'd7, 8'd255, 1'b1));

        d.mode = MODE_GRAY_INV;
        drain();
        load_settings(d);
        send_pixel(px(8'd9, 8'd9, 8'd9, 8'd0, 1'b0));
        send_pixel(px(8'd9, 8'd9, 8'd9, 8'd255, 1'b0));

        d.mode = MODE_GRAY_ADD;
        d.add_rgb = 24'hC8_0000;
        drain();
        load_settings(d);
        send_pixel(px(8'd1, 8'd1, 8'd1, 8'd55, 1'b0));
        send_pixel(px(8'd1, 8'd1, 8'd1, 8'd56, 1'b0));

        d.mode = MODE_RGB_INV;
        drain();
        load_settings(d);
        send_pixel(px(8'd0, 8'd255, 8'd170, 8'd77, 1'b0));

        d.mode = MODE_RGB_ADD;
        d.add_rgb = 24'hFF_0100;
        drain();
        load_settings(d);
        send_pixel(px(8'd1, 8'd255, 8'd254, 8'd9, 1'b0));
        send_pixel(px(8'd0, 8'd0, 8'd0, 8'd9, 1'b1));

        d.mode = MODE_TO_GRAY;
        drain();
        load_settings(d);
        send_pixel(px(8'd255, 8'd255, 8'd255, 8'd0, 1'b0));
        send_pixel(px(8'd2, 8'd2, 8'd1, 8'd200, 1'b0));

        d.mode = MODE_RGB_BELOW;
        d.rgb_high = {9'd256, 9'd0, 9'd128};
        drain();
        load_settings(d);
        send_pixel(px(8'd255, 8'd0, 8'd127, 8'd3, 1'b0));
        send_pixel(px(8'd0, 8'd0, 8'd128, 8'd3, 1'b0));

        d.mode = MODE_RGB_BAND;
        d.rgb_low = {8'd0, 8'd100, 8'd253};
        d.rgb_high = {9'd256, 9'd200, 9'd255};
        drain();
        load_settings(d);
        send_pixel(px(8'd1, 8'd101, 8'd254, 8'd4, 1'b0));
        send_pixel(px(8'd0, 8'd101, 8'd254, 8'd4, 1'b0));

        d.mode = MODE_L1_KEY;
        d.ref_rgb = 24'h0A141E;
        d.dist_threshold = 10'd3;
        drain();
        load_settings(d);
        send_pixel(px(8'd11, 8'd21, 8'd30, 8'd50, 1'b0));
        send_pixel(px(8'd11, 8'd21, 8'd31, 8'd50, 1'b0));

        d.mode = MODE_L2_KEY;
        d.ref_rgb = 24'hFFFFFF;
        d.dist_threshold = 10'd1023;
        drain();
        load_settings(d);
        send_pixel(px(8'd0, 8'd0, 8'd0, 8'd60, 1'b1));

        d.mode = MODE_SPARE;
        drain();
        load_settings(d);
        send_pixel(px(8'd12, 8'd34, 8'd56, 8'd78, 1'b0));

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            d = make_settings(ph);
            drain();
            load_settings(d);
            steady = (ph == STEADY_PHASE);
            if (ph == SQUEEZE_PHASE)
                squeeze_req = 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_pixel(rand_pixel(d));
            steady = 1'b0;
        end

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("pixel_point_op_and_color_key_unit_tb: PASS");
        else
            $display("pixel_point_op_and_color_key_unit_tb: FAIL");
        $finish;
    end

endmodule

@@ pixel_point_op_and_color_key_unit.f @@
src/ppk_pkg.sv
src/ppk_regs.sv
src/ppk_pipe.sv
src/pixel_point_op_and_color_key_unit.sv
src/ppk_checker.sv
dv/ppk_result_checker.sv
dv/pixel_point_op_and_color_key_unit_tb.sv
